>>> hw/rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, constants and the header name table for the request header
// parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int unsigned DEF_MAX_LINES    = 128;
  localparam int unsigned DEF_LENGTH_WIDTH = 32;

  // classification of one byte
  typedef enum logic [2:0] {
    KIND_METHOD   = 3'd0,
    KIND_URL      = 3'd1,
    KIND_VERSION  = 3'd2,
    KIND_NAME     = 3'd3,
    KIND_VALUE    = 3'd4,
    KIND_DELIM    = 3'd5,
    KIND_HDR_END  = 3'd6,
    KIND_IGNORED  = 3'd7
  } kind_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] CL_NAME_LEN = 4'd14;

  // "Content-Length", one character per position
  function automatic logic [7:0] cl_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-serial HTTP/1.1 request header parser: classifies every byte, counts
// lines and extracts the Content-Length value.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in_      | input     | in_valid / in_stall    | in_rx_byte, in_start_req
//  out_     | output    | out_valid / out_stall  | out_byte_kind, out_line_index,
//           |           |                        | out_headers_done,
//           |           |                        | out_body_length,
//           |           |                        | out_length_seen,
//           |           |                        | out_too_many_lines
//
// One item per clock sustained while out_stall is low; each item passes
// through the input register and then the result register. The parse state
// update (one add-and-compare for the length digit) sits between those two
// registers and sets the cycle.
// Reset is synchronous on rst_n and returns the parser to the request line.
// in_stall rises only when an item waits in the input register and the
// result register is held by out_stall; nothing is lost or repeated.
//
module http_request_header_parser
  import hrhp_pkg::*;
#(
  parameter int unsigned MAX_LINES    = DEF_MAX_LINES,
  parameter int unsigned LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_start_req,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_kind,
  output logic [6:0]  out_line_index,
  output logic        out_headers_done,
  output logic [31:0] out_body_length,
  output logic        out_length_seen,
  output logic        out_too_many_lines
);

  localparam int unsigned LC_W = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(MAX_LINES - 1);
  localparam int unsigned PW = LENGTH_WIDTH + 4;  // room for acc*10 + digit
  localparam logic [PW-1:0] ACC_MAX = PW'({LENGTH_WIDTH{1'b1}});

  typedef enum logic [1:0] {
    PH_REQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // value field progress on a header line
  typedef enum logic [1:0] {
    VP_SKIP   = 2'd0,   // first char after the colon still to drop
    VP_DIGITS = 2'd1,
    VP_STOP   = 2'd2
  } vpos_t;

  // input register
  logic        in_v_r;
  logic [7:0]  rx_byte_r;
  logic        start_r;

  // parse state
  phase_t                  phase_r,      phase_nxt;
  logic [1:0]              tok_r,        tok_nxt;
  logic                    colon_r,      colon_nxt;
  logic                    pcr_r,        pcr_nxt;
  logic                    als_r,        als_nxt;
  logic [3:0]              nmp_r,        nmp_nxt;
  logic                    nmm_r,        nmm_nxt;
  vpos_t                   vps_r,        vps_nxt;
  logic [LENGTH_WIDTH-1:0] acc_r,        acc_nxt;
  logic                    lflag_r,      lflag_nxt;
  logic [LC_W-1:0]         lc_r,         lc_nxt;
  logic                    ovf_r,        ovf_nxt;

  // result register
  logic        out_v_r;
  kind_t       kind_r,    kind_nxt;
  logic [6:0]  li_r,      li_nxt;
  logic        done_r;
  logic [31:0] bl_r,      bl_nxt;
  logic        lseen_r;
  logic        tml_r;

  logic                    adv;
  logic [LENGTH_WIDTH-1:0] acc_cur;
  logic [PW-1:0]           acc_ext;
  logic [PW-1:0]           acc_mac;
  logic [LENGTH_WIDTH-1:0] acc_dig;
  logic                    is_digit;
  logic [63:0]             acc64;

  // result register moves when empty or taken
  assign adv      = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !adv;

  // decimal accumulate with saturation: acc*10 + d beyond the width saturates
  assign acc_cur  = start_r ? '0 : acc_r;
  assign acc_ext  = PW'(acc_cur);
  assign is_digit = (rx_byte_r >= CH_ZERO) && (rx_byte_r <= CH_NINE);
  assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + PW'(rx_byte_r - CH_ZERO);
  assign acc_dig  = (acc_mac > ACC_MAX) ? {LENGTH_WIDTH{1'b1}}
                                        : acc_mac[LENGTH_WIDTH-1:0];

  always_comb begin
    // a start flag restarts from the reset state before this byte
    phase_nxt = start_r ? PH_REQ  : phase_r;
    tok_nxt   = start_r ? 2'd0    : tok_r;
    colon_nxt = start_r ? 1'b0    : colon_r;
    pcr_nxt   = start_r ? 1'b0    : pcr_r;
    als_nxt   = start_r ? 1'b1    : als_r;
    nmp_nxt   = start_r ? 4'd0    : nmp_r;
    nmm_nxt   = start_r ? 1'b0    : nmm_r;
    vps_nxt   = start_r ? VP_SKIP : vps_r;
    acc_nxt   = acc_cur;
    lflag_nxt = start_r ? 1'b0    : lflag_r;
    lc_nxt    = start_r ? '0      : lc_r;
    ovf_nxt   = start_r ? 1'b0    : ovf_r;

    li_nxt   = 7'(lc_nxt);
    kind_nxt = KIND_IGNORED;

    if (phase_nxt == PH_DONE) begin
      kind_nxt = KIND_IGNORED;
    end else if (rx_byte_r == CH_LF && pcr_nxt) begin
      pcr_nxt = 1'b0;
      if (als_nxt) begin
        // empty line closes the header
        phase_nxt = PH_DONE;
        kind_nxt  = KIND_HDR_END;
      end else begin
        kind_nxt  = KIND_DELIM;
        phase_nxt = PH_HDR;
        if (lc_nxt == LC_LAST) begin
          ovf_nxt = 1'b1;
        end else begin
          lc_nxt = lc_nxt + LC_W'(1);
        end
        colon_nxt = 1'b0;
        als_nxt   = 1'b1;
        nmp_nxt   = 4'd0;
        nmm_nxt   = 1'b0;
        vps_nxt   = VP_SKIP;
        tok_nxt   = 2'd0;
      end
    end else begin
      // lone CR: fold it in as a content byte of the line first
      if (pcr_nxt) begin
        als_nxt = 1'b0;
        if (phase_nxt == PH_HDR) begin
          if (!colon_nxt) begin
            nmm_nxt = 1'b1;
          end else if (vps_nxt == VP_SKIP) begin
            vps_nxt = VP_DIGITS;
          end else if (vps_nxt == VP_DIGITS) begin
            vps_nxt = VP_STOP;
          end
        end
        pcr_nxt = 1'b0;
      end

      if (rx_byte_r == CH_CR) begin
        pcr_nxt  = 1'b1;
        kind_nxt = KIND_DELIM;
      end else begin
        als_nxt = 1'b0;
        if (phase_nxt == PH_REQ) begin
          if (rx_byte_r == CH_SPACE && tok_nxt < 2'd2) begin
            tok_nxt  = tok_nxt + 2'd1;
            kind_nxt = KIND_DELIM;
          end else begin
            kind_nxt = kind_t'(3'(tok_nxt));
          end
        end else if (!colon_nxt) begin
          if (rx_byte_r == CH_COLON) begin
            colon_nxt = 1'b1;
            if (!nmm_nxt && nmp_nxt == CL_NAME_LEN) begin
              lflag_nxt = 1'b1;
              acc_nxt   = '0;
              vps_nxt   = VP_SKIP;
            end else begin
              vps_nxt = VP_STOP;
            end
            kind_nxt = KIND_DELIM;
          end else begin
            if (!nmm_nxt && nmp_nxt < CL_NAME_LEN && rx_byte_r == cl_char(nmp_nxt)) begin
              nmp_nxt = nmp_nxt + 4'd1;
            end else begin
              nmm_nxt = 1'b1;
            end
            kind_nxt = KIND_NAME;
          end
        end else begin
          if (vps_nxt == VP_SKIP) begin
            vps_nxt = VP_DIGITS;
          end else if (vps_nxt == VP_DIGITS) begin
            if (is_digit) begin
              acc_nxt = acc_dig;
            end else begin
              vps_nxt = VP_STOP;
            end
          end
          kind_nxt = KIND_VALUE;
        end
      end
    end
  end

  // body length shown on 32 bits, clipped above that
  assign acc64  = 64'(acc_nxt);
  assign bl_nxt = (acc64 > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : acc64[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_REQ;
      tok_r   <= 2'd0;
      colon_r <= 1'b0;
      pcr_r   <= 1'b0;
      als_r   <= 1'b1;
      nmp_r   <= 4'd0;
      nmm_r   <= 1'b0;
      vps_r   <= VP_SKIP;
      acc_r   <= '0;
      lflag_r <= 1'b0;
      lc_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
        if (in_valid) begin
          rx_byte_r <= in_rx_byte;
          start_r   <= in_start_req;
        end
      end
      if (adv) begin
        out_v_r <= in_v_r;
        if (in_v_r) begin
          phase_r <= phase_nxt;
          tok_r   <= tok_nxt;
          colon_r <= colon_nxt;
          pcr_r   <= pcr_nxt;
          als_r   <= als_nxt;
          nmp_r   <= nmp_nxt;
          nmm_r   <= nmm_nxt;
          vps_r   <= vps_nxt;
          acc_r   <= acc_nxt;
          lflag_r <= lflag_nxt;
          lc_r    <= lc_nxt;
          ovf_r   <= ovf_nxt;
          kind_r  <= kind_nxt;
          li_r    <= li_nxt;
          done_r  <= (phase_nxt == PH_DONE);
          bl_r    <= bl_nxt;
          lseen_r <= lflag_nxt;
          tml_r   <= ovf_nxt;
        end
      end
    end
  end

  assign out_valid          = out_v_r;
  assign out_byte_kind      = kind_r;
  assign out_line_index     = li_r;
  assign out_headers_done   = done_r;
  assign out_body_length    = bl_r;
  assign out_length_seen    = lseen_r;
  assign out_too_many_lines = tml_r;

  // input is held back only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // end of header and bytes past it report the header as complete
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_byte_kind == KIND_HDR_END || out_byte_kind == KIND_IGNORED))
      |-> out_headers_done)
    else $error("end-of-header kind without headers_done");

  // a parse state change needs an item moving into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && in_v_r) |=> ($stable(lc_r) && $stable(acc_r) && $stable(phase_r)))
    else $error("parse state changed without an item");

endmodule

>>> dv/hrhp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_checker
// Watches both channels of the request header parser, predicts the
// classification of every accepted byte and compares it with the results.
// ----------------------------------------------------------------------------
module hrhp_checker
  import hrhp_pkg::*;
#(
  parameter int unsigned MAX_LINES    = DEF_MAX_LINES,
  parameter int unsigned LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_start_req,

  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_byte_kind,
  input  logic [6:0]  out_line_index,
  input  logic        out_headers_done,
  input  logic [31:0] out_body_length,
  input  logic        out_length_seen,
  input  logic        out_too_many_lines,

  output int unsigned fail_count,
  output int unsigned pending
);

  typedef enum logic [1:0] {PH_REQ_LINE, PH_HEADERS, PH_DONE} phase_e;
  typedef enum logic [1:0] {VAL_SKIP, VAL_DIGITS, VAL_STOP} value_e;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  line;
    logic        done;
    logic [31:0] body_len;
    logic        len_seen;
    logic        overflow;
  } byte_class_t;

  localparam logic [8*14-1:0] CL_TEXT = "Content-Length";
  localparam logic [63:0]     LEN_MAX = {64{1'b1}} >> (64 - LENGTH_WIDTH);

  byte_class_t class_q[$];

  // parser state
  phase_e      ph;
  int unsigned tok;
  bit          colon_seen;
  bit          cr_pending;
  bit          line_empty;
  int unsigned match_pos;
  bit          mismatch;
  value_e      vstate;
  logic [63:0] length_acc;
  bit          length_found;
  int unsigned line_count;
  bit          overflow;

  function automatic void start_line();
    colon_seen = 1'b0;
    line_empty = 1'b1;
    match_pos  = 0;
    mismatch   = 1'b0;
    vstate     = VAL_SKIP;
    tok        = 0;
  endfunction

  function automatic void restart_parse();
    ph           = PH_REQ_LINE;
    cr_pending   = 1'b0;
    length_acc   = '0;
    length_found = 1'b0;
    line_count   = 0;
    overflow     = 1'b0;
    start_line();
  endfunction

  // Content-Length value: first char skipped, digits until a non-digit
  function automatic void take_value(input logic [7:0] b);
    logic [63:0] d;
    case (vstate)
      VAL_SKIP: vstate = VAL_DIGITS;
      VAL_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          d = {56'd0, b - CH_ZERO};
          if (length_acc > (LEN_MAX - d) / 64'd10) length_acc = LEN_MAX;
          else length_acc = length_acc * 64'd10 + d;
        end else begin
          vstate = VAL_STOP;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic kind_t take_content(input logic [7:0] b);
    line_empty = 1'b0;
    if (ph == PH_REQ_LINE) begin
      if (b == CH_SPACE && tok < 2) begin
        tok++;
        return KIND_DELIM;
      end
      return (tok == 0) ? KIND_METHOD : (tok == 1) ? KIND_URL : KIND_VERSION;
    end
    if (!colon_seen) begin
      if (b == CH_COLON) begin
        colon_seen = 1'b1;
        if (!mismatch && match_pos == CL_NAME_LEN) begin
          length_found = 1'b1;
          length_acc   = '0;
          vstate       = VAL_SKIP;
        end else begin
          vstate = VAL_STOP;
        end
        return KIND_DELIM;
      end
      if (!mismatch && match_pos < CL_NAME_LEN) begin
        if (b == CL_TEXT[8*(13-match_pos) +: 8]) match_pos++;
        else mismatch = 1'b1;
      end else begin
        mismatch = 1'b1;
      end
      return KIND_NAME;
    end
    take_value(b);
    return KIND_VALUE;
  endfunction

  function automatic byte_class_t classify_byte(input logic [7:0] b, input logic start);
    byte_class_t r;
    kind_t       k;
    int unsigned li;
    if (start) restart_parse();
    li = line_count;
    if (ph == PH_DONE) begin
      k = KIND_IGNORED;
    end else if (b == CH_LF && cr_pending) begin
      cr_pending = 1'b0;
      if (line_empty) begin
        ph = PH_DONE;
        k  = KIND_HDR_END;
      end else begin
        k  = KIND_DELIM;
        ph = PH_HEADERS;
        if (line_count + 1 >= MAX_LINES) overflow = 1'b1;
        else line_count++;
        start_line();
      end
    end else begin
      // a CR not followed by LF turns into content of its line
      if (cr_pending) begin
        k          = take_content(CH_CR);
        cr_pending = 1'b0;
      end
      if (b == CH_CR) begin
        cr_pending = 1'b1;
        k          = KIND_DELIM;
      end else begin
        k = take_content(b);
      end
    end
    r.kind     = k;
    r.line     = li[6:0];
    r.done     = (ph == PH_DONE);
    r.body_len = (length_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : length_acc[31:0];
    r.len_seen = length_found;
    r.overflow = overflow;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    byte_class_t want;
    if (!rst_n) begin
      restart_parse();
      class_q.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0)
        class_q.push_back(classify_byte(in_rx_byte, in_start_req));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (class_q.size() == 0) begin
          $error("result with no item pending: byte_kind %0d", out_byte_kind);
          fail_count++;
        end else begin
          want = class_q.pop_front();
          check_field("byte_kind", 32'(want.kind), 32'(out_byte_kind));
          check_field("line_index", 32'(want.line), 32'(out_line_index));
          check_field("headers_done", 32'(want.done), 32'(out_headers_done));
          check_field("body_length", want.body_len, out_body_length);
          check_field("length_seen", 32'(want.len_seen), 32'(out_length_seen));
          check_field("too_many_lines", 32'(want.overflow), 32'(out_too_many_lines));
        end
      end
    end
    pending = class_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the request header parser: feeds request byte streams with
// random gaps and result stalls; the checker predicts and compares every
// item, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import hrhp_pkg::*;

  localparam int unsigned ITEMS          = 1400; // no new request once this many are sent
  localparam int unsigned TAIL           = 150;  // last items run with no idling
  localparam int unsigned WATCHDOG_LIMIT = 1000; // cycles with nothing accepted

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_start_req = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_kind;
  logic [6:0]  out_line_index;
  logic        out_headers_done;
  logic [31:0] out_body_length;
  logic        out_length_seen;
  logic        out_too_many_lines;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned items_sent = 0;
  bit          tail_phase = 1'b0;  // no idling on either side
  bit          idle_mode  = 1'b1;  // sender gaps allowed for this request
  logic [7:0]  byte_q[$];          // bytes of the request being built

  http_request_header_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_start_req       (in_start_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_kind      (out_byte_kind),
    .out_line_index     (out_line_index),
    .out_headers_done   (out_headers_done),
    .out_body_length    (out_body_length),
    .out_length_seen    (out_length_seen),
    .out_too_many_lines (out_too_many_lines)
  );

  hrhp_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts, with calm
  // stretches in between so that long runs at full rate happen too.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;

  always @(posedge clk) begin
    if (!rst_n || tail_phase) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      out_stall <= 1'b0;
      calm_left = $urandom_range(40, 150);
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang on either channel ends the run.
  // --------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte level driving
  // --------------------------------------------------------------------------

  // One item: an optional idle gap, then hold until taken.
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (idle_mode && !tail_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_start_req <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    tail_phase = (items_sent >= ITEMS - TAIL);
  endtask

  // start_req only ever goes with the first byte of the queue
  task automatic send_queue(input bit with_start);
    for (int i = 0; i < byte_q.size(); i++)
      send_byte(byte_q[i], with_start && i == 0);
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Request building
  // --------------------------------------------------------------------------
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    byte_q.push_back(CH_CR);
    byte_q.push_back(CH_LF);
  endtask

  // printable token char, now and then a high byte
  function automatic logic [7:0] token_char(input bit no_colon);
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (no_colon && c == CH_COLON);
    return c;
  endfunction

  task automatic push_token(input int unsigned len, input bit no_colon);
    repeat (len) byte_q.push_back(token_char(no_colon));
  endtask

  task automatic push_digits(input int unsigned n);
    repeat (n) byte_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Content-Length value: skipped lead char, digits, maybe junk and more
  // digits that must not count.
  task automatic push_length_value();
    if ($urandom_range(0, 4) != 0) byte_q.push_back(CH_SPACE);
    else byte_q.push_back(token_char(1'b0));
    if ($urandom_range(0, 3) == 0) push_digits($urandom_range(10, 14)); // may saturate
    else push_digits($urandom_range(0, 6));                             // 0: empty value
    if ($urandom_range(0, 2) == 0) begin
      byte_q.push_back($urandom_range(0, 1) ? CH_SPACE : token_char(1'b0));
      push_digits($urandom_range(1, 4));
    end
  endtask

  task automatic build_request();
    int unsigned n_hdr;
    byte_q.delete();
    case ($urandom_range(0, 4))
      0: push_text("GET");
      1: push_text("POST");
      2: push_text("PUT");
      3: push_text("HEAD");
      default: push_text("DELETE");
    endcase
    byte_q.push_back(CH_SPACE);
    byte_q.push_back("/");
    push_token($urandom_range(0, 8), 1'b0);
    byte_q.push_back(CH_SPACE);
    push_text("HTTP/1.1");
    push_crlf();
    n_hdr = $urandom_range(0, 5);
    repeat (n_hdr) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_text("Content-Length:");
          push_length_value();
        end
        4: begin
          // near misses: never a length line
          case ($urandom_range(0, 3))
            0: push_text("content-length:");
            1: push_text("Content-Lengt:");
            2: push_text("Content-Lengthx:");
            default: push_text("Content-Length :");
          endcase
          push_length_value();
        end
        default: begin
          push_token($urandom_range(1, 10), 1'b1);
          byte_q.push_back(CH_COLON);
          repeat ($urandom_range(0, 10))
            byte_q.push_back($urandom_range(0, 5) == 0 ? CH_SPACE : token_char(1'b0));
        end
      endcase
      push_crlf();
    end
    push_crlf();
    // trailing bytes after the header end are ignored
    repeat ($urandom_range(0, 3)) byte_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Corrupt a well-formed request: lone CR or LF, dropped or replaced bytes,
  // or a cut that ends the request in mid-line.
  task automatic break_request();
    int unsigned pos;
    repeat ($urandom_range(1, 3)) begin
      pos = $urandom_range(0, byte_q.size() - 1);
      case ($urandom_range(0, 4))
        0: byte_q.insert(pos, CH_CR);
        1: byte_q.insert(pos, CH_LF);
        2: if (byte_q.size() > 1) byte_q.delete(pos);
        3: byte_q[pos] = 8'($urandom_range(0, 255));
        default: while (byte_q.size() > pos + 1) byte_q.delete(byte_q.size() - 1);
      endcase
    end
  endtask

  task automatic build_noise();
    byte_q.delete();
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(0, 9) < 7) begin
        byte_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0: byte_q.push_back(CH_CR);
          1: byte_q.push_back(CH_LF);
          2: byte_q.push_back(CH_SPACE);
          default: byte_q.push_back(CH_COLON);
        endcase
      end
    end
  endtask

  // More lines than the parser counts; a length header past the limit
  // shows that parsing goes on.
  task automatic build_long();
    byte_q.delete();
    push_text("GET / HTTP/1.1");
    push_crlf();
    for (int i = 0; i < 132; i++) begin
      if (i == 130) begin
        push_text("Content-Length: 4321");
      end else begin
        push_token($urandom_range(1, 2), 1'b1);
      end
      push_crlf();
    end
    push_crlf();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned pick;
    bit          long_done;
    bit          pause_done;
    long_done  = 1'b0;
    pause_done = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty request line ends the header at once, then bytes
    // after the end (both byte extremes) are ignored.
    byte_q.delete();
    push_crlf();
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h00);
    send_queue(1'b1);

    // Directed: colon on the request line, extra space inside the version,
    // lone CR and lone LF as content, a header line starting with a colon,
    // then the empty line.
    byte_q.delete();
    push_text("G: / H 1");
    byte_q.push_back(CH_CR);
    byte_q.push_back("x");
    byte_q.push_back(CH_LF);
    push_crlf();
    byte_q.push_back(CH_COLON);
    push_crlf();
    push_crlf();
    send_queue(1'b1);

    // Random: mostly well-formed requests with random content.
    while (items_sent < ITEMS) begin
      idle_mode = ($urandom_range(0, 3) != 0);
      if (!long_done && items_sent > 200) begin
        build_long();
        long_done = 1'b1;
        send_queue(1'b1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          build_request();
          send_queue(1'b1);
        end else if (pick < 9) begin
          build_request();
          break_request();
          send_queue($urandom_range(0, 9) != 0);
        end else begin
          build_noise();
          send_queue(1'($urandom_range(0, 1)));
        end
      end
      if (!pause_done && items_sent >= ITEMS / 2) begin
        wait_drained();
        pause_done = 1'b1;
      end
    end

    // let every result come back, then keep watching for stray ones
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_header_parser.sv
dv/hrhp_checker.sv
dv/tb.sv
